[rtl/srsd_pkg.sv]
// ----------------------------------------------------------------------------
// srsd_pkg: shared types and constants of the stitch record stream decoder
// Holds the record phase encoding, the result kinds and the record codes.
// ----------------------------------------------------------------------------
package srsd_pkg;

  // Width of the header byte counter; covers header lengths up to 511 bytes.
  localparam int HDR_CNT_W = 9;

  localparam int BYTE_W = 8;
  localparam int STEP_W = 16;
  localparam int KIND_W = 3;

  // Position inside the byte stream.
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_FIRST,
    PH_SECOND,
    PH_PAD,
    PH_CODE,
    PH_XLO,
    PH_XHI,
    PH_YLO,
    PH_YHI
  } phase_t;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NORMAL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRIM   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRUNC  = 3'd4;

  // Byte values with a meaning of their own.
  localparam logic [BYTE_W-1:0] LONG_MARK = 8'h80;
  localparam logic [BYTE_W-1:0] CODE_STOP = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_STOP_ALT = 8'hE1;
  localparam logic [BYTE_W-1:0] CODE_TRIM = 8'h03;
  localparam logic [BYTE_W-1:0] CODE_END  = 8'h7E;

  // One decoded result, with a flag that says it is present.
  typedef struct packed {
    logic                     valid;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic [KIND_W-1:0]        kind;
  } result_t;

endpackage

[rtl/stitch_record_stream_decoder.sv]
// ----------------------------------------------------------------------------
// stitch_record_stream_decoder: stitch file byte stream to stitch moves
// Drops a fixed-length header, then decodes short and long stitch records.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                                     per transaction
//   in_      input      in_valid/in_ready, data_byte, final_byte  one file byte
//   out_     output     out_valid/out_ready, step_x, step_y, kind one stitch
//
// The block takes one byte per cycle while in_ready is high. A byte is decoded in the cycle it is
// accepted, and a result that it completes appears on the out_ channel in
// the next cycle, from a single result register.
// in_ready is high whenever the result register is empty or is being emptied
// in the same cycle, so a stall downstream stops input only while a result
// waits there.
// Reset (rst_n low at a rising edge) returns the decoder to the start of the
// header and drops any result that was waiting.
// After the end code or the byte flagged as final, the block keeps accepting
// bytes and discards them until reset.
//
// Records: a short record is two signed bytes (dx, dy). A byte of 0x80 opens
// a long record: a pad byte, a code byte, then dx and dy as little-endian
// signed 16-bit values. A stream that ends inside a record gives a truncated
// record result with zero motion.
// ----------------------------------------------------------------------------
module stitch_record_stream_decoder #(
  parameter int HEADER_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [srsd_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                                in_final_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [srsd_pkg::STEP_W-1:0]  out_step_x,
  output logic signed [srsd_pkg::STEP_W-1:0]  out_step_y,
  output logic [srsd_pkg::KIND_W-1:0]         out_stitch_kind
);

  srsd_pkg::result_t res;
  logic              slot_free;
  logic              byte_fire;

  assign in_ready  = slot_free;
  assign byte_fire = in_valid && slot_free;

  // Phase tracking and result formation.
  srsd_decode #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .data_byte (in_data_byte),
    .final_byte(in_final_byte),
    .res       (res)
  );

  // Result register toward the consumer.
  srsd_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .slot_free      (slot_free),
    .out_step_x     (out_step_x),
    .out_step_y     (out_step_y),
    .out_stitch_kind(out_stitch_kind)
  );

endmodule

[rtl/srsd_decode.sv]
// ----------------------------------------------------------------------------
// srsd_decode: record phase tracker and result builder
// Follows the byte stream through header and records and forms one result.
// ----------------------------------------------------------------------------
module srsd_decode #(
  parameter int HEADER_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_fire,
  input  logic [srsd_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          final_byte,
  output srsd_pkg::result_t             res
);

  localparam logic [srsd_pkg::HDR_CNT_W-1:0] HDR_LIMIT =
    srsd_pkg::HDR_CNT_W'(HEADER_BYTES);
  localparam srsd_pkg::phase_t PHASE_RESET =
    (HEADER_BYTES == 0) ? srsd_pkg::PH_FIRST : srsd_pkg::PH_HEADER;

  srsd_pkg::phase_t phase_r, phase_nxt;
  logic [srsd_pkg::HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [srsd_pkg::BYTE_W-1:0]    first_r, first_nxt;
  logic [srsd_pkg::BYTE_W-1:0]    code_r, code_nxt;
  logic [srsd_pkg::BYTE_W-1:0]    low_r, low_nxt;
  logic [srsd_pkg::STEP_W-1:0]    xhold_r, xhold_nxt;
  logic                           finished_r, finished_nxt;

  logic                           take;
  logic                           rec_done;
  logic [srsd_pkg::HDR_CNT_W-1:0] hdr_inc;

  assign take    = byte_fire && !finished_r;
  assign hdr_inc = hdr_cnt_r + 1'b1;

  // A byte that closes a record (or is a header byte) leaves no partial record.
  assign rec_done = (phase_r == srsd_pkg::PH_HEADER) ||
                    (phase_r == srsd_pkg::PH_SECOND) ||
                    (phase_r == srsd_pkg::PH_YHI);

  // Next state.
  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    first_nxt    = first_r;
    code_nxt     = code_r;
    low_nxt      = low_r;
    xhold_nxt    = xhold_r;
    finished_nxt = finished_r;
    if (take) begin
      unique case (phase_r)
        srsd_pkg::PH_HEADER: begin
          hdr_cnt_nxt = hdr_inc;
          if (hdr_inc >= HDR_LIMIT) begin
            phase_nxt = srsd_pkg::PH_FIRST;
          end
        end
        srsd_pkg::PH_FIRST: begin
          first_nxt = data_byte;
          phase_nxt = (data_byte == srsd_pkg::LONG_MARK) ? srsd_pkg::PH_PAD
                                                         : srsd_pkg::PH_SECOND;
        end
        srsd_pkg::PH_SECOND: phase_nxt = srsd_pkg::PH_FIRST;
        srsd_pkg::PH_PAD:    phase_nxt = srsd_pkg::PH_CODE;
        srsd_pkg::PH_CODE: begin
          code_nxt  = data_byte;
          phase_nxt = srsd_pkg::PH_XLO;
        end
        srsd_pkg::PH_XLO: begin
          low_nxt   = data_byte;
          phase_nxt = srsd_pkg::PH_XHI;
        end
        srsd_pkg::PH_XHI: begin
          xhold_nxt = {data_byte, low_r};
          phase_nxt = srsd_pkg::PH_YLO;
        end
        srsd_pkg::PH_YLO: begin
          low_nxt   = data_byte;
          phase_nxt = srsd_pkg::PH_YHI;
        end
        srsd_pkg::PH_YHI: begin
          phase_nxt = srsd_pkg::PH_FIRST;
          if (code_r == srsd_pkg::CODE_END) begin
            finished_nxt = 1'b1;
          end
        end
        default: phase_nxt = srsd_pkg::PH_FIRST;
      endcase
      if (final_byte) begin
        finished_nxt = 1'b1;
      end
    end
  end

  // Result of the current byte.
  always_comb begin
    res.valid  = 1'b0;
    res.step_x = '0;
    res.step_y = '0;
    res.kind   = srsd_pkg::KIND_NORMAL;
    if (take) begin
      if (final_byte && !rec_done) begin
        res.valid = 1'b1;
        res.kind  = srsd_pkg::KIND_TRUNC;
      end else if (phase_r == srsd_pkg::PH_SECOND) begin
        res.valid  = 1'b1;
        res.step_x = srsd_pkg::STEP_W'(signed'(first_r));
        res.step_y = srsd_pkg::STEP_W'(signed'(data_byte));
      end else if (phase_r == srsd_pkg::PH_YHI) begin
        res.valid = 1'b1;
        if (code_r == srsd_pkg::CODE_END) begin
          res.kind = srsd_pkg::KIND_END;
        end else begin
          res.step_x = xhold_r;
          res.step_y = {data_byte, low_r};
          if (code_r == srsd_pkg::CODE_STOP || code_r == srsd_pkg::CODE_STOP_ALT) begin
            res.kind = srsd_pkg::KIND_STOP;
          end else if (code_r == srsd_pkg::CODE_TRIM) begin
            res.kind = srsd_pkg::KIND_TRIM;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PHASE_RESET;
      hdr_cnt_r  <= '0;
      first_r    <= '0;
      code_r     <= '0;
      low_r      <= '0;
      xhold_r    <= '0;
      finished_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      first_r    <= first_nxt;
      code_r     <= code_nxt;
      low_r      <= low_nxt;
      xhold_r    <= xhold_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

[rtl/srsd_out_reg.sv]
// ----------------------------------------------------------------------------
// srsd_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module srsd_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srsd_pkg::result_t                   res,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                slot_free,
  output logic signed [srsd_pkg::STEP_W-1:0]  out_step_x,
  output logic signed [srsd_pkg::STEP_W-1:0]  out_step_y,
  output logic [srsd_pkg::KIND_W-1:0]         out_stitch_kind
);

  logic                               valid_r;
  logic signed [srsd_pkg::STEP_W-1:0] x_r, y_r;
  logic [srsd_pkg::KIND_W-1:0]        kind_r;

  // The slot frees in the same cycle its transaction completes.
  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      x_r    <= res.step_x;
      y_r    <= res.step_y;
      kind_r <= res.kind;
    end
  end

  assign out_valid       = valid_r;
  assign out_step_x      = x_r;
  assign out_step_y      = y_r;
  assign out_stitch_kind = kind_r;

endmodule

[rtl/srsd_checker.sv]
// ----------------------------------------------------------------------------
// srsd_checker: port-level checks of the stitch record stream decoder
// Watches both channels and flags behavior the decoder must never show.
// ----------------------------------------------------------------------------
module srsd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [srsd_pkg::STEP_W-1:0] out_step_x,
  input logic signed [srsd_pkg::STEP_W-1:0] out_step_y,
  input logic [srsd_pkg::KIND_W-1:0]        out_stitch_kind
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_x) &&
      $stable(out_step_y) && $stable(out_stitch_kind))
    else $error("result changed while stalled");

  // With nothing waiting in the result register, input is never refused.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty result register");

  // A new result only follows an accepted input byte.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |-> $past(in_valid && in_ready))
    else $error("result without an accepted byte");

  // End and truncated results carry no motion.
  a_zero_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_stitch_kind == srsd_pkg::KIND_END ||
                  out_stitch_kind == srsd_pkg::KIND_TRUNC)
      |-> out_step_x == '0 && out_step_y == '0)
    else $error("end or truncated result with motion");

endmodule

bind stitch_record_stream_decoder srsd_checker u_srsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_step_x     (out_step_x),
  .out_step_y     (out_step_y),
  .out_stitch_kind(out_stitch_kind)
);

[sim/stitch_record_stream_decoder_tb.sv]
// ----------------------------------------------------------------------------
// stitch_record_stream_decoder_tb: self-checking bench for the stitch decoder
// Feeds one stitch file through the decoder: header, directed records, a long
// run of random short and long records, a randomly chosen way to end the file
// and bytes after the end. A predictor running beside the block queues the
// stitches it should produce, and every out_ transaction is checked against
// the oldest queued stitch. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stitch_record_stream_decoder_tb;

  localparam int HDR_LEN     = 256;
  localparam int ITEM_TARGET = 2000;
  localparam int TIMEOUT_NS  = 5_000_000;

  // One stitch as it leaves the out_ channel.
  typedef struct packed {
    logic signed [srsd_pkg::STEP_W-1:0] step_x;
    logic signed [srsd_pkg::STEP_W-1:0] step_y;
    logic [srsd_pkg::KIND_W-1:0]        kind;
  } stitch_t;

  // Ready patterns of the downstream side; each one holds for a random stretch.
  typedef enum int {
    RX_STREAM,
    RX_HALF,
    RX_CHOKED,
    RX_MOSTLY
  } rx_mode_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [srsd_pkg::BYTE_W-1:0]        in_data_byte = '0;
  logic                               in_final_byte = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [srsd_pkg::STEP_W-1:0] out_step_x;
  logic signed [srsd_pkg::STEP_W-1:0] out_step_y;
  logic [srsd_pkg::KIND_W-1:0]        out_stitch_kind;

  stitch_record_stream_decoder #(
    .HEADER_BYTES (HDR_LEN)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_step_x      (out_step_x),
    .out_step_y      (out_step_y),
    .out_stitch_kind (out_stitch_kind)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder predictor. It keeps its own copy of the decoder state and is
  // advanced once per accepted input transaction. The dy high byte of a long
  // record has no case of its own here; it falls to the default branch,
  // which closes the long record.
  // --------------------------------------------------------------------------
  srsd_pkg::phase_t               dec_phase;
  logic [srsd_pkg::HDR_CNT_W-1:0] hdr_cnt;
  logic [srsd_pkg::BYTE_W-1:0]    dx_byte;
  logic [srsd_pkg::BYTE_W-1:0]    code_byte;
  logic [srsd_pkg::BYTE_W-1:0]    lo_byte;
  logic [srsd_pkg::STEP_W-1:0]    long_dx;
  logic                           stream_done;

  // Stitches that the decoder owes us, oldest first.
  stitch_t expected_stitches[$];

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;

  function automatic void clear_decoder_state();
    dec_phase   = srsd_pkg::PH_HEADER;
    hdr_cnt     = '0;
    dx_byte     = '0;
    code_byte   = '0;
    lo_byte     = '0;
    long_dx     = '0;
    stream_done = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [srsd_pkg::BYTE_W-1:0] b,
                                      input logic last);
    logic    closed;
    logic    emit;
    stitch_t s;
    closed = 1'b0;
    emit   = 1'b0;
    s      = '0;
    // Once the stream has ended, nothing is decoded until reset.
    if (stream_done) return;
    // A zero-length header hands the very first byte to the record decoder.
    if (dec_phase == srsd_pkg::PH_HEADER && hdr_cnt >= HDR_LEN)
      dec_phase = srsd_pkg::PH_FIRST;
    case (dec_phase)
      srsd_pkg::PH_HEADER: begin
        hdr_cnt = hdr_cnt + 1'b1;
        if (hdr_cnt >= HDR_LEN) dec_phase = srsd_pkg::PH_FIRST;
        closed = 1'b1;
      end
      srsd_pkg::PH_FIRST: begin
        dx_byte   = b;
        dec_phase = (b == srsd_pkg::LONG_MARK) ? srsd_pkg::PH_PAD : srsd_pkg::PH_SECOND;
      end
      srsd_pkg::PH_SECOND: begin
        s.step_x  = {{(srsd_pkg::STEP_W-srsd_pkg::BYTE_W){dx_byte[srsd_pkg::BYTE_W-1]}},
                     dx_byte};
        s.step_y  = {{(srsd_pkg::STEP_W-srsd_pkg::BYTE_W){b[srsd_pkg::BYTE_W-1]}}, b};
        s.kind    = srsd_pkg::KIND_NORMAL;
        emit      = 1'b1;
        closed    = 1'b1;
        dec_phase = srsd_pkg::PH_FIRST;
      end
      srsd_pkg::PH_PAD: begin
        dec_phase = srsd_pkg::PH_CODE;
      end
      srsd_pkg::PH_CODE: begin
        code_byte = b;
        dec_phase = srsd_pkg::PH_XLO;
      end
      srsd_pkg::PH_XLO: begin
        lo_byte   = b;
        dec_phase = srsd_pkg::PH_XHI;
      end
      srsd_pkg::PH_XHI: begin
        long_dx   = {b, lo_byte};
        dec_phase = srsd_pkg::PH_YLO;
      end
      srsd_pkg::PH_YLO: begin
        lo_byte   = b;
        dec_phase = srsd_pkg::PH_YHI;
      end
      default: begin
        emit      = 1'b1;
        closed    = 1'b1;
        dec_phase = srsd_pkg::PH_FIRST;
        if (code_byte == srsd_pkg::CODE_END) begin
          // The end marker carries no motion and closes the stream.
          s.kind      = srsd_pkg::KIND_END;
          stream_done = 1'b1;
        end else begin
          s.step_x = long_dx;
          s.step_y = {b, lo_byte};
          if (code_byte == srsd_pkg::CODE_STOP || code_byte == srsd_pkg::CODE_STOP_ALT) begin
            s.kind = srsd_pkg::KIND_STOP;
          end else if (code_byte == srsd_pkg::CODE_TRIM) begin
            s.kind = srsd_pkg::KIND_TRIM;
          end else begin
            s.kind = srsd_pkg::KIND_NORMAL;
          end
        end
      end
    endcase
    // The flagged last byte ends the stream; if it leaves a record open, the
    // decoder reports a truncated record with zero motion instead.
    if (last) begin
      if (!closed) begin
        s      = '0;
        s.kind = srsd_pkg::KIND_TRUNC;
        emit   = 1'b1;
      end
      stream_done = 1'b1;
    end
    if (emit) expected_stitches.push_back(s);
  endfunction

  // --------------------------------------------------------------------------
  // Error reporting and the result checker.
  // --------------------------------------------------------------------------
  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  stitch_t head_stitch;

  // Every out_ transaction is compared field by field with the oldest
  // expectation. Outputs are read in the active region right after the edge,
  // so they still hold the values that the edge itself sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_stitches.size() == 0) begin
        report_error($sformatf("unexpected stitch x=%0d y=%0d kind=%0d",
                               out_step_x, out_step_y, out_stitch_kind));
      end else begin
        head_stitch = expected_stitches.pop_front();
        if (out_step_x !== head_stitch.step_x)
          report_error($sformatf("step_x got %0d expected %0d",
                                 out_step_x, head_stitch.step_x));
        if (out_step_y !== head_stitch.step_y)
          report_error($sformatf("step_y got %0d expected %0d",
                                 out_step_y, head_stitch.step_y));
        if (out_stitch_kind !== head_stitch.kind)
          report_error($sformatf("stitch_kind got %0d expected %0d",
                                 out_stitch_kind, head_stitch.kind));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Downstream stall pattern. A mode is held for a random stretch of cycles:
  // always ready, coin flip, heavily choked or mostly ready. The always-ready
  // stretches give the block runs with no back pressure at all.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_left = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_CHOKED: out_ready <= ($urandom_range(0, 5) == 0);
      default:   out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender. Bytes go out in bursts of random length; between bursts the valid
  // line drops for a random gap, and some bursts follow each other with no
  // gap. Valid is only ever lowered at a step where it is not also raised.
  // The predictor sees a byte at the edge that accepts it.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [srsd_pkg::BYTE_W-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    decode_byte(b, last);
  endtask

  // Short record; flag_at picks the byte that carries the last-byte flag
  // (0 or 1), any other value means none.
  task automatic send_short(input logic [srsd_pkg::BYTE_W-1:0] dx,
                            input logic [srsd_pkg::BYTE_W-1:0] dy,
                            input int flag_at);
    send_byte(dx, flag_at == 0);
    send_byte(dy, flag_at == 1);
  endtask

  // Long record: mark, pad, code, dx low/high, dy low/high. flag_at works as
  // for send_short over the seven bytes.
  task automatic send_long(input logic [srsd_pkg::BYTE_W-1:0] code,
                           input logic [srsd_pkg::STEP_W-1:0] dx,
                           input logic [srsd_pkg::STEP_W-1:0] dy, input int flag_at);
    logic [srsd_pkg::BYTE_W-1:0] rec [7];
    rec = '{srsd_pkg::LONG_MARK, srsd_pkg::BYTE_W'($urandom), code,
            dx[7:0], dx[15:8], dy[7:0], dy[15:8]};
    for (int i = 0; i < 7; i++) send_byte(rec[i], flag_at == i);
  endtask

  // Holds the sender off until every owed stitch has come out. Valid goes
  // low before the wait begins, so it is never lowered and raised at once.
  task automatic wait_for_stitches();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_stitches.size() != 0);
  endtask

  // Displacements lean on the signed extremes now and then.
  function automatic logic [srsd_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return srsd_pkg::STEP_W'($urandom);
    endcase
  endfunction

  // Long record codes, weighted so the stop, trim and alternate stop codes
  // come up often; the end code is kept for the end of the stream.
  function automatic logic [srsd_pkg::BYTE_W-1:0] pick_code();
    logic [srsd_pkg::BYTE_W-1:0] c;
    case ($urandom_range(0, 5))
      0:       c = srsd_pkg::CODE_STOP;
      1:       c = srsd_pkg::CODE_STOP_ALT;
      2:       c = srsd_pkg::CODE_TRIM;
      default: begin
        c = srsd_pkg::BYTE_W'($urandom);
        if (c == srsd_pkg::CODE_END) c = srsd_pkg::CODE_TRIM;
      end
    endcase
    return c;
  endfunction

  function automatic logic [srsd_pkg::BYTE_W-1:0] pick_short_dx();
    logic [srsd_pkg::BYTE_W-1:0] b;
    b = srsd_pkg::BYTE_W'($urandom);
    if (b == srsd_pkg::LONG_MARK) b = 8'h7F;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // The header is dropped whatever it holds, including the long record mark
  // and the end code.
  task automatic test_header();
    for (int i = 0; i < HDR_LEN; i++) begin
      case (i)
        0:       send_byte(8'h00, 1'b0);
        1:       send_byte(8'hFF, 1'b0);
        2:       send_byte(srsd_pkg::LONG_MARK, 1'b0);
        3:       send_byte(srsd_pkg::CODE_END, 1'b0);
        default: send_byte(srsd_pkg::BYTE_W'($urandom), 1'b0);
      endcase
    end
  endtask

  // Short records at the ends of the signed byte range.
  task automatic test_short_records();
    send_short(8'h7F, 8'h80, -1);
    send_short(8'h81, 8'h7F, -1);
    send_short(8'h00, 8'hFF, -1);
  endtask

  // Long records with the stop and trim codes and 16-bit extremes.
  task automatic test_long_records();
    send_long(srsd_pkg::CODE_STOP, 16'h8000, 16'h7FFF, -1);
    send_long(srsd_pkg::CODE_TRIM, 16'h7FFF, 16'h8000, -1);
  endtask

  // Random mix of short and long records with random content.
  task automatic test_random_records();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 6) begin
        send_short(pick_short_dx(), srsd_pkg::BYTE_W'($urandom), -1);
      end else begin
        send_long(pick_code(), pick_step(), pick_step(), -1);
      end
      // Now and then let the block drain completely before carrying on.
      if ($urandom_range(0, 199) == 0) wait_for_stitches();
    end
  endtask

  // The stream ends one of four ways: the end code, the last byte finishing a
  // short record, the last byte finishing a long record, or the last byte
  // cutting a record short.
  task automatic test_stream_end();
    case ($urandom_range(0, 3))
      0: send_long(srsd_pkg::CODE_END, pick_step(), pick_step(), -1);
      1: send_short(pick_short_dx(), srsd_pkg::BYTE_W'($urandom), 1);
      2: send_long(pick_code(), pick_step(), pick_step(), 6);
      default: begin
        if ($urandom_range(0, 2) == 0) begin
          send_short(pick_short_dx(), srsd_pkg::BYTE_W'($urandom), 0);
        end else begin
          send_long(pick_code(), pick_step(), pick_step(), $urandom_range(0, 5));
        end
      end
    endcase
  endtask

  // After the end nothing may come out, whatever arrives.
  task automatic test_after_end();
    send_long(srsd_pkg::CODE_STOP, 16'h1234, 16'h8765, -1);
    send_short(8'h11, 8'h22, 1);
    send_long(srsd_pkg::CODE_END, 16'h0001, 16'h0002, 3);
    for (int i = 0; i < 10; i++)
      send_byte(srsd_pkg::BYTE_W'($urandom), 1'(($urandom_range(0, 1))));
  endtask

  initial begin
    clear_decoder_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_header();
    test_short_records();
    test_long_records();
    // Drain once before the random part so the sender sees a full pause.
    wait_for_stitches();
    test_random_records();
    test_stream_end();
    test_after_end();

    // Let the last owed stitches out, then keep watching with the input idle
    // to show any stitch it should not produce.
    in_valid <= 1'b0;
    while (expected_stitches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0 && expected_stitches.size() == 0) begin
      $display("stitch_record_stream_decoder verification clean");
    end else begin
      $display("stitch_record_stream_decoder verification failed");
    end
    $finish;
  end

  // Hang guard: a stalled handshake or a stitch that never comes ends here.
  initial begin
    #(TIMEOUT_NS * 1ns);
    $display("stitch_record_stream_decoder verification failed");
    $finish;
  end

endmodule
